// ===== rtl/rldr_pkg.sv =====
package rldr_pkg;

	localparam int CoordW = 21;
	localparam int CoefW  = 24;
	localparam int DiffW  = 22;
	localparam int SqW    = 43;
	localparam int RootW  = 22;
	localparam int AccW   = 41;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 24;
	localparam int RootSteps = 11;
	localparam int BitsPerStep = 2;
	localparam int TdataW = 128;

	localparam logic [CfgIdxW-1:0] REG_CUBIC  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_SQUARE = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_LINEAR = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_CONST  = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_CX     = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_CY     = 3'd5;

	localparam logic signed [AccW-1:0] AccMax = 41'sd549755813888;
	localparam logic signed [AccW-1:0] AccMin = -41'sd549755813888;

	typedef struct packed {
		logic [SqW-1:0]   rem;
		logic [RootW-1:0] root;
	} root_state_t;

	// exact square of an offset, always non-negative
	function automatic logic [SqW+1:0] square(logic signed [DiffW-1:0] d);
		logic signed [2*DiffW-1:0] p;
		p = d * d;
		return {1'b0, p};
	endfunction

	// one digit of the restoring square root, taking one radicand bit pair, msb pair first
	function automatic root_state_t root_step(root_state_t s, logic [SqW+1:0] v, int k);
		logic [SqW+1:0] trial;
		logic [SqW+1:0] rem;
		root_state_t    o;
		rem = {2'b00, s.rem[SqW-3:0], v[2*k+1 -: 2]};
		trial = {{(SqW-RootW){1'b0}}, s.root, 2'b01};
		o.root = s.root << 1;
		if (rem >= trial) begin
			rem = rem - trial;
			o.root[0] = 1'b1;
		end
		o.rem = rem[SqW-1:0];
		return o;
	endfunction

	// t*r/2^16 floored, plus k, clamped to +-2^39
	function automatic logic signed [AccW-1:0] horner(logic signed [AccW-1:0] t,
			logic [RootW-1:0] r, logic signed [CoefW-1:0] k);
		logic signed [AccW+RootW:0] p;
		logic signed [AccW+RootW:0] s;
		p = t * $signed({1'b0, r});
		s = (p >>> 16) + k;
		if (s > AccMax) return AccMax;
		if (s < AccMin) return AccMin;
		return s[AccW-1:0];
	endfunction

	function automatic logic [CoordW-1:0] outmap(logic signed [DiffW-1:0] d,
			logic signed [AccW-1:0] t, logic signed [CoordW-1:0] c);
		logic signed [DiffW+AccW-1:0] p;
		logic signed [DiffW+AccW-1:0] s;
		p = d * t;
		s = (p >>> 20) + c;
		if (s > 64'sd1048575) return 21'h0fffff;
		if (s < -64'sd1048576) return 21'h100000;
		return s[CoordW-1:0];
	endfunction

endpackage

// ===== rtl/radial_lens_distortion_remap_unit.sv =====
// channel   | dir | handshake          | payload
// s_axis    | in  | s_axis_tvalid/ready | tdata: red_x,red_y,green_x,green_y,blue_x,blue_y
// m_axis    | out | m_axis_tvalid/ready | tdata: src_ red..blue x,y
// cfg       | in  | cfg_we             | cfg_index, cfg_data
// pipeline stages: offset, sum of squares, square-root digits, polynomial, output map
// one transfer per cycle sustained unless the output stalls; the whole pipe advances when the output is free
// stall: pipeline holds while m_axis_tready is low and the last stage is full
// reset clears the coefficient registers and all stage valid bits
module radial_lens_distortion_remap_unit (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	input  logic [rldr_pkg::TdataW-1:0] s_axis_tdata, // red_x,red_y,green_x,green_y,blue_x,blue_y
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	output logic [rldr_pkg::TdataW-1:0] m_axis_tdata, // src_red_x .. src_blue_y
	input  logic cfg_we,
	input  logic [rldr_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [rldr_pkg::CfgDataW-1:0] cfg_data
);
	import rldr_pkg::*;

	localparam int NS = RootSteps + 6;

	logic signed [CoefW-1:0] a_q, b_q, c_q, d_q;
	logic signed [CoordW-1:0] cx_q, cy_q;

	// per stage, per channel
	logic [NS-1:0] vld_q;
	logic signed [DiffW-1:0] dx_q [NS-1][3];
	logic signed [DiffW-1:0] dy_q [NS-1][3];
	logic [SqW+1:0]          sq_q [1:RootSteps+1][3];
	root_state_t             rt_q [1:RootSteps+3][3];
	logic signed [AccW-1:0]  t_q  [RootSteps+2:RootSteps+4][3];
	logic [CoordW-1:0]       ox_q [3], oy_q [3];

	logic adv;
	assign adv = !vld_q[NS-1] || m_axis_tready;
	assign s_axis_tready = adv;
	assign m_axis_tvalid = vld_q[NS-1];

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0; cx_q <= '0; cy_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_CUBIC:  a_q <= cfg_data;
				REG_SQUARE: b_q <= cfg_data;
				REG_LINEAR: c_q <= cfg_data;
				REG_CONST:  d_q <= cfg_data;
				REG_CX:     cx_q <= cfg_data[CoordW-1:0];
				REG_CY:     cy_q <= cfg_data[CoordW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else if (adv) vld_q <= {vld_q[NS-2:0], s_axis_tvalid};
	end

	// stage 0: offsets; stage 1: sum of squares
	// stages 2..12: square-root digits; 13..15: polynomial; 16: output
	always_ff @(posedge clk) begin
		if (adv) begin
			for (int ch = 0; ch < 3; ch++) begin
				dx_q[0][ch] <= $signed(s_axis_tdata[2*ch*CoordW +: CoordW]) - cx_q;
				dy_q[0][ch] <= $signed(s_axis_tdata[(2*ch+1)*CoordW +: CoordW]) - cy_q;
				for (int s = 1; s < NS-1; s++) begin
					dx_q[s][ch] <= dx_q[s-1][ch];
					dy_q[s][ch] <= dy_q[s-1][ch];
				end
				sq_q[1][ch] <= square(dx_q[0][ch]) + square(dy_q[0][ch]);
				for (int s = 2; s <= RootSteps+1; s++)
					sq_q[s][ch] <= sq_q[s-1][ch];
				rt_q[1][ch] <= '0;
				for (int k = 0; k < RootSteps; k++)
					rt_q[k+2][ch] <= root_step(root_step(rt_q[k+1][ch], sq_q[k+1][ch],
						2*RootSteps-1-2*k), sq_q[k+1][ch], 2*RootSteps-2-2*k);
				for (int s = RootSteps+2; s <= RootSteps+3; s++)
					rt_q[s][ch] <= rt_q[s-1][ch];
				t_q[RootSteps+2][ch] <= horner(AccW'(a_q), rt_q[RootSteps+1][ch].root, b_q);
				t_q[RootSteps+3][ch] <= horner(t_q[RootSteps+2][ch],
					rt_q[RootSteps+2][ch].root, c_q);
				t_q[RootSteps+4][ch] <= horner(t_q[RootSteps+3][ch],
					rt_q[RootSteps+3][ch].root, d_q);
				ox_q[ch] <= outmap(dx_q[NS-2][ch], t_q[NS-2][ch], cx_q);
				oy_q[ch] <= outmap(dy_q[NS-2][ch], t_q[NS-2][ch], cy_q);
			end
		end
	end

	always_comb begin
		m_axis_tdata = '0;
		for (int ch = 0; ch < 3; ch++) begin
			m_axis_tdata[2*ch*CoordW +: CoordW]     = ox_q[ch];
			m_axis_tdata[(2*ch+1)*CoordW +: CoordW] = oy_q[ch];
		end
	end

`ifndef SYNTHESIS
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output changed under stall");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready) else $error("stalled with empty output");
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready && !vld_q[NS-2] |=> !m_axis_tvalid) else $error("bubble lost");
`endif

endmodule

// ===== test/radial_lens_distortion_remap_checker.sv =====
`timescale 1ns / 100ps

module radial_lens_distortion_remap_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	input  logic s_axis_tready,
	input  logic [rldr_pkg::TdataW-1:0] s_axis_tdata,
	input  logic m_axis_tvalid,
	input  logic m_axis_tready,
	input  logic [rldr_pkg::TdataW-1:0] m_axis_tdata,
	input  logic cfg_we,
	input  logic [rldr_pkg::CfgIdxW-1:0] cfg_index,
	input  logic [rldr_pkg::CfgDataW-1:0] cfg_data,
	output int   errors,
	output int   outstanding
);
	import rldr_pkg::*;

	localparam longint StageLim = 64'sd1 <<< 39;
	localparam longint PosMin   = -(64'sd1 <<< 20);
	localparam longint PosMax   = (64'sd1 <<< 20) - 1;

	longint coef_a, coef_b, coef_c, coef_d, shift_x, shift_y;
	logic [6*CoordW-1:0] source_queue[$];

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= res + bitv) begin
				n = n - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return res;
	endfunction

	function automatic longint sat(longint v, longint lo, longint hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// source positions for all three channels of one pixel
	function automatic logic [6*CoordW-1:0] source_of(logic [TdataW-1:0] d);
		logic [6*CoordW-1:0] res;
		longint dx, dy, r, t, ox, oy;
		res = '0;
		for (int ch = 0; ch < 3; ch++) begin
			dx = longint'($signed(d[2*ch*CoordW +: CoordW])) - shift_x;
			dy = longint'($signed(d[(2*ch+1)*CoordW +: CoordW])) - shift_y;
			r = longint'(int_sqrt(longint'(dx*dx + dy*dy)));
			t = coef_a;
			t = sat(((t * r) >>> 16) + coef_b, -StageLim, StageLim);
			t = sat(((t * r) >>> 16) + coef_c, -StageLim, StageLim);
			t = sat(((t * r) >>> 16) + coef_d, -StageLim, StageLim);
			ox = sat(((dx * t) >>> 20) + shift_x, PosMin, PosMax);
			oy = sat(((dy * t) >>> 20) + shift_y, PosMin, PosMax);
			res[2*ch*CoordW +: CoordW] = ox[CoordW-1:0];
			res[(2*ch+1)*CoordW +: CoordW] = oy[CoordW-1:0];
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic [6*CoordW-1:0] want;
		if (!arst_n) begin
			coef_a = 0; coef_b = 0; coef_c = 0; coef_d = 0;
			shift_x = 0; shift_y = 0;
			errors = 0;
			source_queue.delete();
			outstanding = 0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				source_queue.push_back(source_of(s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (source_queue.size() == 0) begin
					$display("%0t: unexpected result %h", $time, m_axis_tdata);
					errors++;
				end else begin
					want = source_queue.pop_front();
					for (int f = 0; f < 6; f++)
						if (m_axis_tdata[f*CoordW +: CoordW] !== want[f*CoordW +: CoordW]) begin
							$display("%0t: field %0d expected %h actual %h", $time, f,
								want[f*CoordW +: CoordW], m_axis_tdata[f*CoordW +: CoordW]);
							errors++;
						end
				end
			end
			outstanding = source_queue.size();
			if (cfg_we) begin
				case (cfg_index)
					REG_CUBIC:  coef_a = longint'($signed(cfg_data));
					REG_SQUARE: coef_b = longint'($signed(cfg_data));
					REG_LINEAR: coef_c = longint'($signed(cfg_data));
					REG_CONST:  coef_d = longint'($signed(cfg_data));
					REG_CX:     shift_x = longint'($signed(cfg_data[CoordW-1:0]));
					REG_CY:     shift_y = longint'($signed(cfg_data[CoordW-1:0]));
					default: ;
				endcase
			end
		end
	end

endmodule

// ===== test/radial_lens_distortion_remap_unit_tb.sv =====
`timescale 1ns / 100ps

module radial_lens_distortion_remap_unit_tb;
	import rldr_pkg::*;

	// indexes past the register list, writes there must be dropped
	localparam logic [CfgIdxW-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CfgIdxW-1:0] REG_SPARE_HI = 3'd7;
	localparam int StallLimit = 5000;
	localparam int DrainCycles = 25;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [TdataW-1:0] s_axis_tdata = '0; // red_x,red_y,green_x,green_y,blue_x,blue_y,pad
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [TdataW-1:0] m_axis_tdata; // src red_x,red_y,green_x,green_y,blue_x,blue_y,pad
	logic cfg_we = 1'b0;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [CfgDataW-1:0] cfg_data = '0;
	int errors, outstanding;
	int quiet_cycles = 0;
	bit no_idle = 1'b0;
	logic [CoordW-1:0] cur_cx = '0, cur_cy = '0;

	radial_lens_distortion_remap_unit DUT (.*);

	radial_lens_distortion_remap_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side backpressure, about one cycle in ten
	always @(negedge clk)
		m_axis_tready <= no_idle || ($urandom_range(99) >= 10);

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= StallLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		if (idx == REG_CX) cur_cx = val[CoordW-1:0];
		if (idx == REG_CY) cur_cy = val[CoordW-1:0];
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// one pixel transfer, with random source gaps
	task automatic send_pixel(logic [6*CoordW-1:0] px);
		while (!no_idle && $urandom_range(99) < 10) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tdata = {2'b00, px};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
		s_axis_tvalid = 1'b0;
	endtask

	// wait for the pipe to empty before touching registers
	task automatic drain();
		while (outstanding != 0) @(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	function automatic logic [CoordW-1:0] pick_coord(bit is_y);
		logic [CoordW-1:0] c;
		c = is_y ? cur_cy : cur_cx;
		case ($urandom_range(9))
			0: return $urandom_range(1) ? 21'h0fffff : 21'h100000;
			1: return c;
			2, 3: return c + CoordW'($signed($urandom_range(8191)) - 4096);
			default: return CoordW'($urandom);
		endcase
	endfunction

	function automatic logic [6*CoordW-1:0] random_pixel();
		logic [6*CoordW-1:0] px;
		bit centred;
		centred = ($urandom_range(19) == 0);
		for (int f = 0; f < 6; f++)
			px[f*CoordW +: CoordW] = centred ? ((f % 2) ? cur_cy : cur_cx) : pick_coord(f[0]);
		return px;
	endfunction

	task automatic load_coefs(logic [23:0] a, logic [23:0] b, logic [23:0] c, logic [23:0] d,
			logic [23:0] cx, logic [23:0] cy);
		write_reg(REG_CUBIC, a);
		write_reg(REG_SQUARE, b);
		write_reg(REG_LINEAR, c);
		write_reg(REG_CONST, d);
		write_reg(REG_CX, cx);
		write_reg(REG_CY, cy);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset coefficients: everything collapses onto the centre
		send_pixel({6{21'h0fffff}});
		send_pixel({6{21'h100000}});
		send_pixel('0);
		drain();

		// identity-like scale plus mild distortion
		load_coefs(24'hfffff0, 24'h000100, 24'hfff000, 24'h100000, 24'h012345, 24'hfe0000);
		write_reg(REG_SPARE_LO, 24'h7fffff);
		write_reg(REG_SPARE_HI, 24'h800000);
		send_pixel({cur_cy, cur_cx, cur_cy, cur_cx, cur_cy, cur_cx});
		send_pixel({6{21'h0fffff}});
		send_pixel({6{21'h100000}});
		send_pixel({21'h100000, 21'h0fffff, 21'h0fffff, 21'h100000, 21'h000001, 21'h1fffff});
		send_pixel({cur_cy + 21'd1, cur_cx, cur_cy, cur_cx - 21'd1, cur_cy, cur_cx + 21'd1});
		drain();

		// saturating extremes, upper centre bits must be ignored
		load_coefs(24'h7fffff, 24'h7fffff, 24'h7fffff, 24'h7fffff, 24'he0ffff, 24'h1fffff);
		send_pixel({6{21'h100000}});
		send_pixel({cur_cy, cur_cx, 21'h0fffff, 21'h100000, 21'h000000, 21'h0fffff});
		drain();
		load_coefs(24'h800000, 24'h800000, 24'h800000, 24'h800000, 24'hf00000, 24'h0fffff);
		send_pixel({6{21'h0fffff}});
		send_pixel({cur_cy, cur_cx, 21'h100000, 21'h0fffff, 21'h000000, 21'h100000});
		drain();

		// random phases, each under a fresh register setting
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: load_coefs(24'h000000, 24'h000000, 24'h000000, 24'h100000, 24'h000000,
					24'h000000);
				1: load_coefs(24'h7fffff, 24'h800000, 24'h7fffff, 24'h800000, 24'($urandom),
					24'($urandom));
				default: load_coefs(24'($urandom_range(511) - 256),
					24'($urandom_range(4095) - 2048),
					24'($urandom_range(65535) - 32768),
					24'(24'h0c0000 + $urandom_range(524287)),
					24'($urandom), 24'($urandom));
			endcase
			if (ph == 5) load_coefs(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
				24'($urandom), 24'($urandom));
			for (int n = 0; n < 150; n++) begin
				no_idle = (ph == 3 && n >= 30 && n < 110);
				send_pixel(random_pixel());
			end
			no_idle = 1'b0;
			drain();
		end

		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
